// File: rtl/core/abtd_pkg.sv
// Shared types and constants for the affine block transposition decryptor.
package abtd_pkg;

    localparam int BLOCK_LEN_W = 7;
    localparam int MULT_KEY_W  = 8;
    localparam int ADD_KEY_W   = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int DIV_W       = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_LEN = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MULT_KEY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ADD_KEY   = 2'd2;

    localparam logic [BLOCK_LEN_W-1:0] BLOCK_LEN_RESET = 7'd2;
    localparam logic [MULT_KEY_W-1:0]  MULT_KEY_RESET  = 8'd1;
    localparam logic [ADD_KEY_W-1:0]   ADD_KEY_RESET   = 16'd0;

    localparam logic [7:0] TAB_BYTE = 8'h09;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    typedef logic [1:0] div_sel_t;
    localparam div_sel_t DIV_SEL_KEY  = 2'd0;
    localparam div_sel_t DIV_SEL_OFS  = 2'd1;
    localparam div_sel_t DIV_SEL_PROD = 2'd2;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       end_of_text;
    } cipher_in_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       last_of_block;
        logic       key_invalid;
    } plain_out_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     bm_load;
        logic     km_load;
        logic     inv_step;
        logic     inv_latch;
        logic     emit_init;
        logic     emit_step;
        logic     out_load;
    } abtd_cmd_t;

    typedef struct packed {
        logic block_full;
        logic div_busy;
        logic inv_hit;
        logic inv_end;
        logic last_item;
        logic out_free;
    } abtd_status_t;

endpackage

// File: rtl/core/abtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module abtd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/abtd_ctrl.sv
// Sequencing state machine: block fill, key reductions, inverse search, emission.
module abtd_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  abtd_pkg::abtd_status_t status,
    output abtd_pkg::abtd_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MODB = 3'd1;
    localparam logic [2:0] ST_MODK = 3'd2;
    localparam logic [2:0] ST_INV  = 3'd3;
    localparam logic [2:0] ST_MODC = 3'd4;
    localparam logic [2:0] ST_RD   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        cmd.accept = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && status.block_full) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = abtd_pkg::DIV_SEL_OFS;
                    state_next    = ST_MODB;
                end
            end
            ST_MODB: begin
                if (!status.div_busy) begin
                    cmd.bm_load   = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = abtd_pkg::DIV_SEL_KEY;
                    state_next    = ST_MODK;
                end
            end
            ST_MODK: begin
                if (!status.div_busy) begin
                    cmd.km_load = 1'b1;
                    state_next  = ST_INV;
                end
            end
            ST_INV: begin
                if (status.inv_hit || status.inv_end) begin
                    cmd.inv_latch = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = abtd_pkg::DIV_SEL_PROD;
                    state_next    = ST_MODC;
                end else begin
                    cmd.inv_step = 1'b1;
                end
            end
            ST_MODC: begin
                if (!status.div_busy) begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (status.last_item) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.emit_step = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a completing byte must hold off the next transaction until the block is out
    a_full_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.block_full) |=> !s_ready)
        else $error("input accepted right after a block completed");

endmodule

// File: rtl/core/abtd_datapath.sv
// Datapath: config registers, block buffer, shared remainder unit, output register.
module abtd_datapath #(
    parameter int BLOCK_MAX = 64,
    localparam int NW = $clog2(BLOCK_MAX + 1),
    localparam int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [abtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [abtd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  abtd_pkg::cipher_in_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output abtd_pkg::plain_out_t                m_data,
    input  abtd_pkg::abtd_cmd_t                 cmd,
    output abtd_pkg::abtd_status_t              status
);

    localparam int CW = $clog2(abtd_pkg::DIV_W);

    logic [abtd_pkg::BLOCK_LEN_W-1:0] block_len_reg;
    logic [abtd_pkg::MULT_KEY_W-1:0]  mult_key_reg;
    logic [abtd_pkg::ADD_KEY_W-1:0]   add_key_reg;

    logic [NW-1:0] n_eff;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_inc;

    logic                       div_busy_reg;
    logic [CW-1:0]              div_cnt_reg;
    logic [abtd_pkg::DIV_W-1:0] div_dvd_reg;
    logic [NW-1:0]              div_rem_reg;
    logic [abtd_pkg::DIV_W-1:0] div_operand;
    logic [abtd_pkg::DIV_W-1:0] ofs_mag;
    logic [NW:0]                rem_sh;
    logic [NW:0]                rem_sub;
    logic [NW-1:0]              rem_nxt;

    logic [NW-1:0]   bm_reg;
    logic [NW-1:0]   km_reg;
    logic [NW-1:0]   srch_i_reg;
    logic [NW-1:0]   srch_r_reg;
    logic [NW:0]     r_add;
    logic [NW-1:0]   inv_reg;
    logic [NW-1:0]   inv_cand;
    logic [2*NW-1:0] prod;

    logic [NW-1:0] k_reg;
    logic [NW:0]   k_add;
    logic [NW-1:0] emit_cnt_reg;

    logic [7:0]           rd_data;
    logic                 m_valid_reg;
    abtd_pkg::plain_out_t m_data_reg;
    logic [7:0]           plain_sel;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_len_reg <= abtd_pkg::BLOCK_LEN_RESET;
            mult_key_reg  <= abtd_pkg::MULT_KEY_RESET;
            add_key_reg   <= abtd_pkg::ADD_KEY_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                abtd_pkg::CFG_BLOCK_LEN: block_len_reg <= cfg_wdata[abtd_pkg::BLOCK_LEN_W-1:0];
                abtd_pkg::CFG_MULT_KEY:  mult_key_reg  <= cfg_wdata[abtd_pkg::MULT_KEY_W-1:0];
                abtd_pkg::CFG_ADD_KEY:   add_key_reg   <= cfg_wdata[abtd_pkg::ADD_KEY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (block_len_reg < 7'd2) begin
            n_eff = NW'(2);
        end else if (block_len_reg > 7'(BLOCK_MAX)) begin
            n_eff = NW'(BLOCK_MAX);
        end else begin
            n_eff = NW'(block_len_reg);
        end
    end

    // block fill
    assign fill_inc = fill_reg + NW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.accept) begin
            if (fill_inc >= n_eff || s_data.end_of_text) begin
                fill_reg <= '0;
            end else begin
                fill_reg <= fill_inc;
            end
        end
    end

    abtd_ram #(
        .WIDTH (8),
        .DEPTH (BLOCK_MAX)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (cmd.accept),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_data.cipher_byte),
        .rd_addr (k_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // shared restoring remainder unit, one dividend bit per cycle
    assign ofs_mag  = add_key_reg[abtd_pkg::ADD_KEY_W-1] ? (~add_key_reg + 16'd1) : add_key_reg;
    assign inv_cand = (srch_r_reg == NW'(1)) ? srch_i_reg : '0;
    assign prod     = inv_cand * bm_reg;

    always_comb begin
        case (cmd.div_sel)
            abtd_pkg::DIV_SEL_KEY:  div_operand = abtd_pkg::DIV_W'(mult_key_reg);
            abtd_pkg::DIV_SEL_OFS:  div_operand = ofs_mag;
            abtd_pkg::DIV_SEL_PROD: div_operand = abtd_pkg::DIV_W'(prod);
            default:                div_operand = '0;
        endcase
    end

    assign rem_sh  = {div_rem_reg, div_dvd_reg[abtd_pkg::DIV_W-1]};
    assign rem_sub = rem_sh - {1'b0, n_eff};
    assign rem_nxt = (rem_sh >= {1'b0, n_eff}) ? rem_sub[NW-1:0] : rem_sh[NW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else if (cmd.div_start) begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end else if (div_busy_reg) begin
            div_cnt_reg <= div_cnt_reg + CW'(1);
            if (div_cnt_reg == CW'(abtd_pkg::DIV_W - 1)) begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            div_dvd_reg <= div_operand;
            div_rem_reg <= '0;
        end else if (div_busy_reg) begin
            div_dvd_reg <= {div_dvd_reg[abtd_pkg::DIV_W-2:0], 1'b0};
            div_rem_reg <= rem_nxt;
        end
    end

    // offset, inverse search and read-index walk
    assign r_add = {1'b0, srch_r_reg} + {1'b0, km_reg};
    assign k_add = {1'b0, k_reg} + {1'b0, inv_reg};

    always_ff @(posedge aclk) begin
        if (cmd.bm_load) begin
            if (add_key_reg[abtd_pkg::ADD_KEY_W-1] && div_rem_reg != '0) begin
                bm_reg <= n_eff - div_rem_reg;
            end else begin
                bm_reg <= div_rem_reg;
            end
        end
        if (cmd.km_load) begin
            km_reg     <= div_rem_reg;
            srch_i_reg <= NW'(1);
            srch_r_reg <= div_rem_reg;
        end else if (cmd.inv_step) begin
            srch_i_reg <= srch_i_reg + NW'(1);
            if (r_add >= {1'b0, n_eff}) begin
                srch_r_reg <= NW'(r_add - {1'b0, n_eff});
            end else begin
                srch_r_reg <= r_add[NW-1:0];
            end
        end
        if (cmd.inv_latch) begin
            inv_reg <= inv_cand;
        end
        if (cmd.emit_init) begin
            k_reg        <= (div_rem_reg == '0) ? '0 : (n_eff - div_rem_reg);
            emit_cnt_reg <= '0;
        end else if (cmd.emit_step) begin
            emit_cnt_reg <= emit_cnt_reg + NW'(1);
            if (k_add >= {1'b0, n_eff}) begin
                k_reg <= NW'(k_add - {1'b0, n_eff});
            end else begin
                k_reg <= k_add[NW-1:0];
            end
        end
    end

    // output register
    assign plain_sel = (inv_reg == '0 || rd_data == abtd_pkg::TAB_BYTE) ?
                       abtd_pkg::NUL_BYTE : rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.plain_byte    <= plain_sel;
            m_data_reg.last_of_block <= (emit_cnt_reg == n_eff - NW'(1));
            m_data_reg.key_invalid   <= (inv_reg == '0);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.block_full = (fill_inc >= n_eff);
    assign status.div_busy   = div_busy_reg;
    assign status.inv_hit    = (srch_r_reg == NW'(1));
    assign status.inv_end    = (srch_i_reg == n_eff - NW'(1));
    assign status.last_item  = (emit_cnt_reg == n_eff - NW'(1));
    assign status.out_free   = !m_valid_reg || m_ready;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < NW'(BLOCK_MAX))
        else $error("fill count beyond buffer depth");

    a_read_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (k_reg < n_eff))
        else $error("read index outside the block");

    a_invalid_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.key_invalid) |-> (m_data_reg.plain_byte == abtd_pkg::NUL_BYTE))
        else $error("invalid key transaction carries a non-zero byte");

endmodule

// File: rtl/core/affine_block_transposition_decrypt.sv
// Top level of the affine block transposition decryptor.
// A byte that does not complete a block is taken while the input stays ready.
// A completing byte starts the key work: offset reduction, key reduction, inverse search
// and product reduction, in that order; then the block is emitted from the buffer.
// Each result: buffer read, then output load, held while the output stalls; no input meanwhile.
// Reset clears control state, fill count and registers (2, 1, 0); buffer is not cleared.
module affine_block_transposition_decrypt #(
    parameter int BLOCK_MAX = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [abtd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [abtd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  abtd_pkg::cipher_in_t             s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output abtd_pkg::plain_out_t             m_data
);

    abtd_pkg::abtd_cmd_t    cmd;
    abtd_pkg::abtd_status_t status;

    abtd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    abtd_datapath #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
